// ===== hw/rtl/idmn_pkg.sv =====
package idmn_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int DIV_BITS      = 32;
  localparam int ALU_BITS      = DIV_BITS + 1;
  localparam int NIB_BITS      = 4;
  localparam int NIB_COUNT     = DIV_BITS / NIB_BITS;
  localparam int NIB_IDX_BITS  = $clog2(NIB_COUNT);
  localparam int MULT_BITS     = 33;
  localparam int SHIFT_BITS    = 5;
  localparam int OUT_DATA_BITS = 48;
  localparam int OUT_USER_BITS = 4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOG,
    S_DIV,
    S_ADJ,
    S_RED,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    KIND_IDENT,
    KIND_POW2,
    KIND_SHORT,
    KIND_ADDBACK
  } kind_t;

  typedef struct packed {
    logic [ALU_BITS-1:0] diff;
    logic                borrow;
  } alu_res_t;

  function automatic logic [2:0] bitlen4(input logic [NIB_BITS-1:0] n);
    logic [2:0] len;
    len = 3'd0;
    for (int i = 0; i < NIB_BITS; i++) begin
      if (n[i]) begin
        len = 3'(i + 1);
      end
    end
    return len;
  endfunction

endpackage

// ===== hw/rtl/idmn_alu.sv =====
module idmn_alu
  import idmn_pkg::*;
(
  input  logic [ALU_BITS-1:0] op_a,
  input  logic [ALU_BITS-1:0] op_b,
  output alu_res_t            res
);

  logic [ALU_BITS:0] wide;

  assign wide       = {1'b0, op_a} - {1'b0, op_b};
  assign res.diff   = wide[ALU_BITS-1:0];
  assign res.borrow = wide[ALU_BITS];

endmodule

// ===== hw/rtl/invariant_division_magic_number.sv =====
// A zero divisor skips straight to the result and is flagged invalid.
// One shared subtractor serves the WORD_BITS+2 restoring division steps, the add-back steps
// and up to l+1 reduction steps; the log takes up to 8 nibble scans.
// One divisor is processed at a time; the next is taken once the result is registered,
// while that result may still wait in the output register.
// Reset: synchronous active-low rst_n clears the sequencer and the output valid.
module invariant_division_magic_number
  import idmn_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [DIV_BITS-1:0]      in_tdata,   // [31:0] divisor
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,  // [32:0] multiplier, [37:33] post_shift,
                                               // [42:38] ceil_log, [47:43] zero
  output logic [OUT_USER_BITS-1:0] out_tuser   // [1:0] sequence_kind, [2] negate_result,
                                               // [3] invalid
);

  localparam int QW = WORD_BITS + 2;
  localparam int CW = $clog2(QW);

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [DIV_BITS-1:0]      mag_r, mag_nxt;
  logic [DIV_BITS-1:0]      mm1_r, mm1_nxt;
  logic                     neg_r, neg_nxt;
  logic                     zero_r, zero_nxt;
  logic [SHIFT_BITS-1:0]    l_r, l_nxt;
  logic [SHIFT_BITS-1:0]    sh_r, sh_nxt;
  logic [ALU_BITS-1:0]      rem_r, rem_nxt;
  logic [QW-1:0]            low_r, low_nxt;
  logic [QW-1:0]            high_r, high_nxt;
  logic [OUT_DATA_BITS-1:0] out_data_r, out_data_nxt;
  logic [OUT_USER_BITS-1:0] out_user_r, out_user_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic [ALU_BITS-1:0]      op_a, op_b;
  alu_res_t                 alu;

  logic [NIB_IDX_BITS-1:0]  nib_idx;
  logic [NIB_BITS-1:0]      nib;
  logic [SHIFT_BITS-1:0]    l_found;
  logic                     bit_in;
  logic [ALU_BITS-1:0]      rem_sel;
  logic [QW-1:0]            q_next;
  logic                     load;
  kind_t                    kind;

  idmn_alu u_alu (
    .op_a (op_a),
    .op_b (op_b),
    .res  (alu)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign nib_idx = cnt_r[NIB_IDX_BITS-1:0];
  assign nib     = mm1_r[{nib_idx, 2'b00} +: NIB_BITS];
  assign l_found = SHIFT_BITS'({1'b0, nib_idx, 2'b00} + 6'(bitlen4(nib)));
  assign bit_in  = ((l_r == 5'd0) && (cnt_r == CW'(WORD_BITS))) ||
                   ((l_r == 5'd1) && (cnt_r == CW'(WORD_BITS + 1)));
  assign rem_sel = alu.borrow ? op_a : alu.diff;
  assign q_next  = {low_r[QW-2:0], ~alu.borrow};

  always_comb begin
    priority if (mag_r == DIV_BITS'(1)) begin
      kind = KIND_IDENT;
    end else if ((mag_r & mm1_r) == '0) begin
      kind = KIND_POW2;
    end else if ((high_r >> (WORD_BITS - 1)) == '0) begin
      kind = KIND_SHORT;
    end else begin
      kind = KIND_ADDBACK;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    mag_nxt      = mag_r;
    mm1_nxt      = mm1_r;
    neg_nxt      = neg_r;
    zero_nxt     = zero_r;
    l_nxt        = l_r;
    sh_nxt       = sh_r;
    rem_nxt      = rem_r;
    low_nxt      = low_r;
    high_nxt     = high_r;
    out_data_nxt = out_data_r;
    out_user_nxt = out_user_r;
    op_a         = rem_r;
    op_b         = ALU_BITS'(mag_r);
    load         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          neg_nxt   = in_tdata[DIV_BITS-1];
          mag_nxt   = in_tdata[DIV_BITS-1] ? (~in_tdata + DIV_BITS'(1)) : in_tdata;
          mm1_nxt   = in_tdata[DIV_BITS-1] ? ~in_tdata : (in_tdata - DIV_BITS'(1));
          zero_nxt  = (in_tdata == '0);
          cnt_nxt   = CW'(NIB_COUNT - 1);
          state_nxt = (in_tdata == '0) ? S_DONE : S_LOG;
        end
      end
      S_LOG: begin
        if ((nib != '0) || (nib_idx == '0)) begin
          l_nxt     = l_found;
          rem_nxt   = (l_found >= 5'd2) ? (ALU_BITS'(1) << (l_found - 5'd2)) : '0;
          low_nxt   = '0;
          cnt_nxt   = CW'(QW - 1);
          state_nxt = S_DIV;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      S_DIV: begin
        op_a    = {rem_r[DIV_BITS-1:0], bit_in};
        rem_nxt = rem_sel;
        low_nxt = q_next;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          high_nxt  = q_next;
          rem_nxt   = rem_sel | (ALU_BITS'(1) << (6'(l_r) + 6'd1));
          state_nxt = S_ADJ;
        end
      end
      S_ADJ: begin
        if (!alu.borrow) begin
          rem_nxt  = alu.diff;
          high_nxt = high_r + QW'(1);
        end else begin
          sh_nxt    = l_r;
          state_nxt = S_RED;
        end
      end
      S_RED: begin
        op_a = ALU_BITS'(low_r >> 1);
        op_b = ALU_BITS'(high_r >> 1);
        if (alu.borrow && (sh_r != '0)) begin
          low_nxt  = low_r >> 1;
          high_nxt = high_r >> 1;
          sh_nxt   = sh_r - SHIFT_BITS'(1);
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          load      = 1'b1;
          state_nxt = S_IDLE;
          if (zero_r) begin
            out_data_nxt = '0;
            out_user_nxt = {1'b1, 1'b0, KIND_IDENT};
          end else begin
            out_data_nxt = OUT_DATA_BITS'({l_r, sh_r, MULT_BITS'(high_r)});
            out_user_nxt = {1'b0, neg_r, kind};
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    mag_r      <= mag_nxt;
    mm1_r      <= mm1_nxt;
    neg_r      <= neg_nxt;
    zero_r     <= zero_nxt;
    l_r        <= l_nxt;
    sh_r       <= sh_nxt;
    rem_r      <= rem_nxt;
    low_r      <= low_nxt;
    high_r     <= high_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != S_IDLE))
    else $error("sequencer stayed idle after an accepted beat");

  a_shift_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RED) |-> (sh_r <= l_r))
    else $error("post shift exceeds ceil log");

  a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_ADJ) || (state_r == S_RED)) |-> (high_r >= low_r))
    else $error("high bound fell below low bound");

  a_invalid_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_user_r[3]) |-> ((out_data_r == '0) && (out_user_r[2:0] == '0)))
    else $error("invalid beat carries nonzero fields");

  a_out_shift_le_log: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_user_r[3]) |-> (out_data_r[37:33] <= out_data_r[42:38]))
    else $error("output shift exceeds output ceil log");

endmodule

// ===== bench/idmn_checker.sv =====
`timescale 1ns / 1ps

module idmn_checker
  import idmn_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  input  logic                     in_tready,
  input  logic [DIV_BITS-1:0]      in_tdata,
  input  logic                     out_tvalid,
  input  logic                     out_tready,
  input  logic [OUT_DATA_BITS-1:0] out_tdata,
  input  logic [OUT_USER_BITS-1:0] out_tuser,
  output int                       pending,
  output int                       errors
);

  typedef struct {
    logic [MULT_BITS-1:0]  multiplier;
    logic [SHIFT_BITS-1:0] post_shift;
    logic [SHIFT_BITS-1:0] ceil_log;
    kind_t                 kind;
    logic                  negate;
    logic                  invalid;
  } div_plan_t;

  div_plan_t plans_due[$];

  initial begin
    pending = 0;
    errors  = 0;
  end

  function automatic div_plan_t magic_plan(input logic [DIV_BITS-1:0] d);
    div_plan_t   p;
    logic [63:0] mag;
    logic [63:0] top;
    logic [63:0] lo;
    logic [63:0] hi;
    int          l;
    int          sh;
    p.multiplier = '0;
    p.post_shift = '0;
    p.ceil_log   = '0;
    p.kind       = KIND_IDENT;
    p.negate     = 1'b0;
    p.invalid    = 1'b0;
    if (d == '0) begin
      p.invalid = 1'b1;
      return p;
    end
    mag = {32'd0, (d[DIV_BITS-1] ? 32'(~d + 32'd1) : d)};
    l = 0;
    while (l < 31 && (64'd1 << l) < mag) begin
      l++;
    end
    top = 64'd1 << (WORD_BITS + l);
    lo  = top / mag;
    hi  = (top + (64'd1 << (l + 1))) / mag;
    sh  = l;
    while ((lo >> 1) < (hi >> 1) && sh > 0) begin
      lo >>= 1;
      hi >>= 1;
      sh--;
    end
    if (mag == 64'd1) begin
      p.kind = KIND_IDENT;
    end else if (mag == (64'd1 << l)) begin
      p.kind = KIND_POW2;
    end else if (hi < (64'd1 << (WORD_BITS - 1))) begin
      p.kind = KIND_SHORT;
    end else begin
      p.kind = KIND_ADDBACK;
    end
    p.multiplier = hi[MULT_BITS-1:0];
    p.post_shift = sh[SHIFT_BITS-1:0];
    p.ceil_log   = l[SHIFT_BITS-1:0];
    p.negate     = d[DIV_BITS-1];
    return p;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t: %s mismatch: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    div_plan_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        plans_due.insert(plans_due.size(), magic_plan(in_tdata));
      end
      if (out_tvalid && out_tready) begin
        if (plans_due.size() == 0) begin
          flag_mismatch("unexpected beat", {16'd0, out_tdata}, 64'd0);
        end else begin
          want = plans_due.pop_front();
          if (out_tdata[32:0] !== want.multiplier) begin
            flag_mismatch("multiplier", 64'(out_tdata[32:0]), 64'(want.multiplier));
          end
          if (out_tdata[37:33] !== want.post_shift) begin
            flag_mismatch("post_shift", 64'(out_tdata[37:33]), 64'(want.post_shift));
          end
          if (out_tdata[42:38] !== want.ceil_log) begin
            flag_mismatch("ceil_log", 64'(out_tdata[42:38]), 64'(want.ceil_log));
          end
          if (out_tuser[1:0] !== want.kind) begin
            flag_mismatch("sequence_kind", 64'(out_tuser[1:0]), 64'(want.kind));
          end
          if (out_tuser[2] !== want.negate) begin
            flag_mismatch("negate_result", 64'(out_tuser[2]), 64'(want.negate));
          end
          if (out_tuser[3] !== want.invalid) begin
            flag_mismatch("invalid", 64'(out_tuser[3]), 64'(want.invalid));
          end
        end
      end
      pending <= plans_due.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb
  import idmn_pkg::*;
();

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RAND_ITEMS  = 700;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_tvalid  = 1'b0;
  logic                     in_tready;
  logic [DIV_BITS-1:0]      in_tdata   = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic [OUT_USER_BITS-1:0] out_tuser;

  int pending;
  int errors;
  int cycles   = 0;
  int src_idle = 0;
  int snk_idle = 0;

  invariant_division_magic_number uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  idmn_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .pending   (pending),
    .errors    (errors)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= snk_idle);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_divisor(input logic [DIV_BITS-1:0] d);
    if ($urandom_range(99) < src_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_plans();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [DIV_BITS-1:0] pick_divisor();
    logic [DIV_BITS-1:0] m;
    int                  k;
    k = $urandom_range(31);
    case ($urandom_range(9))
      0, 1, 2: m = $urandom;
      3, 4:    m = $urandom_range(300, 1);
      5:       m = 32'd1 << k;
      6:       m = (32'd1 << k) + 32'd1;
      7:       m = (32'd1 << k) - 32'd1;
      8:       m = $urandom >> k;
      default: m = ($urandom_range(19) == 0) ? 32'd0 : 32'($urandom_range(100000, 1));
    endcase
    if ($urandom_range(1) == 1) begin
      m = ~m + 32'd1;
    end
    return m;
  endfunction

  initial begin
    logic [DIV_BITS-1:0] directed[$];
    int                  src_pct[4];
    int                  snk_pct[4];
    directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFE, 32'd3, 32'hFFFF_FFFD,
                 32'd5, 32'd6, 32'd7, 32'hFFFF_FFF9, 32'd641, 32'd1000, 32'h4000_0000,
                 32'hC000_0000, 32'h4000_0001, 32'h7FFF_FFFF, 32'h8000_0001,
                 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0001_0001,
                 32'hBFFF_FFFF};
    src_pct = '{0, 74, 0, 9};
    snk_pct = '{0, 0, 74, 9};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) begin
      send_divisor(directed[i]);
    end
    drain_plans();
    for (int ph = 0; ph < 4; ph++) begin
      src_idle = src_pct[ph];
      snk_idle = snk_pct[ph];
      for (int n = 0; n < RAND_ITEMS / 4; n++) begin
        send_divisor(pick_divisor());
      end
      drain_plans();
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/idmn_pkg.sv
hw/rtl/idmn_alu.sv
hw/rtl/invariant_division_magic_number.sv
bench/idmn_checker.sv
bench/tb.sv
